### sv/snil_pkg.sv
package snil_pkg;

   localparam int DIST_W             = 17;
   localparam int TAG_W              = 16;
   localparam int RANK_W             = 4;
   localparam int LIST_SLOTS_DEFAULT = 16;
   localparam int QUEUE_DEPTH        = 2;

   // 1.0 in unsigned Q1.16
   localparam logic [DIST_W-1:0] ONE_Q16 = 17'h10000;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [TAG_W-1:0]  item_id;
      logic              end_of_set;
   } req_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [DIST_W-1:0] entry_distance;
      logic [TAG_W-1:0]  entry_tag;
      logic              entry_last;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [TAG_W-1:0]  tag;
      logic              eos;
   } work_type;

   typedef struct packed {
      logic draining;
      logic fill_zero;
   } back_status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_DRAIN
   } back_state_type;

endpackage

### sv/sorted_nearest_insertion_list.sv
// Path: an accepted item is held in the front register, then in the queue, then inserted into the list.
// Throughput: one item per cycle while the list is not draining; an end-of-set item adds a drain
//   that emits one entry per filled slot (1 to LIST_SLOTS), through the single head-of-list read port.
// During the drain each result is loaded into the output register; results stream one per cycle while not stalled.
// Reset (synchronous, active high): list to 1.0, fill count 0, queue and output empty.
module sorted_nearest_insertion_list
   import snil_pkg::*;
#(
   parameter int LIST_SLOTS = LIST_SLOTS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // front -> queue
   logic            push_valid;
   logic            push_ready;
   work_type        push_data;
   // queue -> back
   logic            q_valid;
   logic            q_ready;
   work_type        q_data;
   back_status_type back_status;

   // front: saturate distance, form tag, register the item
   snil_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // short queue decouples intake from a draining list
   snil_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   // back: parallel compare-and-shift insert, drain on end of set
   snil_back #(
      .LIST_SLOTS (LIST_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_valid),
      .pop_ready (q_ready),
      .pop_data  (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .status    (back_status)
   );

`ifndef SYNTHESIS
   // no item leaves the queue while the list drains
   a_no_pop_in_drain: assert property (@(posedge clock) disable iff (reset)
      back_status.draining |-> !(q_valid && q_ready))
      else $error("item popped during drain");

   // an end-of-set item always starts a drain
   a_eos_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready && q_data.eos) |=> back_status.draining)
      else $error("end of set did not start drain");

   // draining an empty list never happens
   a_drain_not_empty: assert property (@(posedge clock) disable iff (reset)
      back_status.draining |-> !back_status.fill_zero)
      else $error("drain with empty list");

   // a stalled entry stays presented and unchanged until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("entry changed while stalled");
`endif

endmodule

### sv/snil_front.sv
module snil_front
   import snil_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     push_valid,
   input  logic     push_ready,
   output work_type push_data
);

   logic     hold_valid_ff;
   logic     hold_valid_in;
   work_type hold_ff;
   work_type hold_in;

   assign req_ready = !hold_valid_ff || push_ready;

   // saturate distance to 1.0, tag is id + 1 (wraps in 16 bits)
   always_comb begin
      hold_in.distance = (req_data.distance > ONE_Q16) ? ONE_Q16 : req_data.distance;
      hold_in.tag      = req_data.item_id + TAG_W'(1);
      hold_in.eos      = req_data.end_of_set;
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_valid && req_ready) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         hold_ff <= hold_in;
      end
   end

   assign push_valid = hold_valid_ff;
   assign push_data  = hold_ff;

endmodule

### sv/snil_queue.sv
module snil_queue
   import snil_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  work_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output work_type pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/snil_back.sv
module snil_back
   import snil_pkg::*;
#(
   parameter int LIST_SLOTS = LIST_SLOTS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  work_type        pop_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data,
   output back_status_type status
);

   localparam int FILL_W = $clog2(LIST_SLOTS + 1);
   localparam int LAST   = LIST_SLOTS - 1;

   back_state_type    state_ff;
   back_state_type    state_in;
   logic [DIST_W-1:0] dist_ff [LIST_SLOTS];
   logic [DIST_W-1:0] dist_in [LIST_SLOTS];
   logic [TAG_W-1:0]  tag_ff  [LIST_SLOTS];
   logic [TAG_W-1:0]  tag_in  [LIST_SLOTS];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [RANK_W-1:0] rank_ff;
   logic [RANK_W-1:0] rank_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   logic              rsp_load;
   logic              out_free;
   logic              last_entry;
   logic [LIST_SLOTS-1:0] lt;

   // thermometer: slots holding a strictly smaller distance
   always_comb begin
      for (int i = 0; i < LIST_SLOTS; i++) begin
         lt[i] = dist_ff[i] < pop_data.distance;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign last_entry = (fill_ff == FILL_W'(1));

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      rank_in   = rank_ff;
      pop_ready = 1'b0;
      rsp_load  = 1'b0;
      for (int i = 0; i < LIST_SLOTS; i++) begin
         dist_in[i] = dist_ff[i];
         tag_in[i]  = tag_ff[i];
      end
      case (state_ff)
         BACK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               // insert ahead of the first slot not smaller, shift the rest down
               if (!lt[0]) begin
                  dist_in[0] = pop_data.distance;
                  tag_in[0]  = pop_data.tag;
               end
               for (int i = 1; i < LIST_SLOTS; i++) begin
                  if (!lt[i]) begin
                     if (lt[i-1]) begin
                        dist_in[i] = pop_data.distance;
                        tag_in[i]  = pop_data.tag;
                     end else begin
                        dist_in[i] = dist_ff[i-1];
                        tag_in[i]  = tag_ff[i-1];
                     end
                  end
               end
               if (!lt[LAST] && (fill_ff != FILL_W'(LIST_SLOTS))) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               if (pop_data.eos) begin
                  state_in = BACK_DRAIN;
               end
            end
         end
         BACK_DRAIN: begin
            if (out_free) begin
               // emit head, shift list up, refill tail with 1.0
               rsp_load = 1'b1;
               for (int i = 0; i < LAST; i++) begin
                  dist_in[i] = dist_ff[i+1];
                  tag_in[i]  = tag_ff[i+1];
               end
               dist_in[LAST] = ONE_Q16;
               fill_in       = fill_ff - FILL_W'(1);
               rank_in       = rank_ff + RANK_W'(1);
               if (last_entry) begin
                  state_in = BACK_IDLE;
                  rank_in  = '0;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         fill_ff      <= '0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LIST_SLOTS; i++) begin
            dist_ff[i] <= ONE_Q16;
         end
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         rank_ff  <= rank_in;
         for (int i = 0; i < LIST_SLOTS; i++) begin
            dist_ff[i] <= dist_in[i];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LIST_SLOTS; i++) begin
         tag_ff[i] <= tag_in[i];
      end
      if (rsp_load) begin
         rsp_data_ff.rank           <= rank_ff;
         rsp_data_ff.entry_distance <= dist_ff[0];
         rsp_data_ff.entry_tag      <= tag_ff[0];
         rsp_data_ff.entry_last     <= last_entry;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign status.draining  = (state_ff == BACK_DRAIN);
   assign status.fill_zero = (fill_ff == '0);

endmodule
